FILE: sv/mahd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mahd_pkg
// shared types, code points and lookup tables of the audio header decoder
// ----------------------------------------------------------------------------
package mahd_pkg;

   localparam int HDR_W     = 32;
   localparam int KBIT_W    = 9;
   localparam int FS_W      = 16;
   localparam int FRAME_W   = 12;
   localparam int COEF_W    = 8;
   localparam int PROD_W    = 17;   // coef1 * kbit
   localparam int NUM_W     = 28;   // (coef1 * kbit << shift) * 1000
   localparam int QUO_W     = 13;   // quotient estimate
   localparam int RECIP_W   = 18;
   localparam int RECIP_SH  = 32;
   localparam int MUL_W     = NUM_W + RECIP_W;

   // request kinds
   localparam logic [1:0] REQ_DECODE    = 2'd0;
   localparam logic [1:0] REQ_STEP_RATE = 2'd1;
   localparam logic [1:0] REQ_CLEAR_CRC = 2'd2;

   // version codes
   localparam logic [1:0] VER_MPEG1    = 2'd0;
   localparam logic [1:0] VER_MPEG2    = 2'd1;
   localparam logic [1:0] VER_MPEG25   = 2'd2;
   localparam logic [1:0] VER_RESERVED = 2'd3;

   // layer codes
   localparam logic [1:0] LAY_I        = 2'd0;
   localparam logic [1:0] LAY_II       = 2'd1;
   localparam logic [1:0] LAY_III      = 2'd2;
   localparam logic [1:0] LAY_RESERVED = 2'd3;

   // bitrate status
   localparam logic [1:0] RATE_NORMAL = 2'd0;
   localparam logic [1:0] RATE_FREE   = 2'd1;
   localparam logic [1:0] RATE_BAD    = 2'd2;

   localparam logic [3:0] BIDX_FREE     = 4'd0;
   localparam logic [3:0] BIDX_LAST     = 4'd14;
   localparam logic [3:0] BIDX_BAD      = 4'd15;
   localparam logic [1:0] SIDX_RESERVED = 2'd3;
   localparam logic [1:0] EMPH_RESERVED = 2'd2;
   localparam logic [10:0] SYNC_WORD    = 11'h7FF;

   localparam logic [COEF_W-1:0] COEF_L1   = 8'd12;
   localparam logic [COEF_W-1:0] COEF_L23  = 8'd144;
   localparam logic [COEF_W-1:0] COEF_L3LS = 8'd72;
   localparam logic [9:0]        KBIT_SCALE = 10'd1000;

   localparam logic [KBIT_W-1:0] KBPS_TAB [5][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   // mpeg1 sample rates; mpeg2 and mpeg2.5 are these shifted right by the version code
   localparam logic [FS_W-1:0] FS_BASE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

   // floor(2^32 / base rate)
   localparam logic [RECIP_W-1:0] FS_RECIP [4] = '{18'd97391, 18'd89478, 18'd134217, 18'd0};

   typedef struct packed {
      logic                hdr_ok;
      logic [1:0]          version;
      logic [1:0]          layer;
      logic [KBIT_W-1:0]   kbit;
      logic [1:0]          rate_status;
      logic [FS_W-1:0]     fs_hz;
      logic                crc;
      logic [3:0]          flags;
      logic [5:0]          stereo;
      logic [HDR_W-1:0]    new_hdr;
      logic                edit_ok;
      logic [COEF_W-1:0]   coef1;
      logic [1:0]          fs_shift;
      logic [1:0]          fs_sel;
      logic                len_ok;
      logic                quad;     // layer I, length counted in 4-byte slots
      logic                pad;
   } mahd_dec_type;

   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
   } mahd_len_ctl_type;

endpackage
`default_nettype wire

FILE: sv/mpeg_audio_header_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// mpeg-1/2/2.5 audio frame header decode, frame length and header edit
// ----------------------------------------------------------------------------
// Takes one 32-bit frame header per request and returns one result per
// request: validity, version and layer, bitrate, sample rate, frame length in
// bytes, the remaining coded fields and an edited copy of the header (bitrate
// index stepped up, or crc protection cleared). A request is taken every
// cycle unless back-pressure from the response side holds the first stage;
// each result passes through five register stages on its way out.
// The stages follow the frame length path: decode and table lookup, the
// coefficient times bitrate product, the scale by 1000 and version shift, the
// reciprocal multiply that divides by the sample rate, and the final
// remainder correction. Every stage has its own valid bit and may fill while
// a later stage is stalled, so a stalled result never blocks empty stages.
// The block keeps no state beyond the pipeline itself.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder import mahd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // header_word
   input  wire logic [1:0]  req_tuser,    // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // header_valid, version_code, layer_code, kbit_rate, rate_status,
   // sample_rate_hz, frame_bytes, crc_protected, flag_bits,
   // stereo_and_emphasis, new_header, edit_ok
   output logic [87:0]      rsp_tdata
);

   mahd_dec_type      dec0;
   mahd_dec_type      dec1_ff, dec2_ff, dec3_ff, dec4_ff;
   mahd_len_ctl_type  len_ctl;
   logic [FRAME_W-1:0] frame_len;
   logic [87:0]       out_ff, out_in;

   // per-stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   // stage can load: empty, or its content moves on this cycle
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = ~v5_ff | rsp_tready;
   assign rdy4 = ~v4_ff | rdy5;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;

   assign req_tready = rdy1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = out_ff;

   // stage 1 logic: field decode, lookups and edit
   mahd_decode u_decode (
      .header_word (req_tdata),
      .req_type    (req_tuser),
      .dec         (dec0)
   );

   assign len_ctl.ld2 = rdy2;
   assign len_ctl.ld3 = rdy3;
   assign len_ctl.ld4 = rdy4;

   // stages 2 to 4 of the frame length path, correction feeds the output stage
   mahd_frame_len u_frame_len (
      .clock       (clock),
      .ctl         (len_ctl),
      .dec1        (dec1_ff),
      .dec2        (dec2_ff),
      .dec3        (dec3_ff),
      .dec4        (dec4_ff),
      .frame_bytes (frame_len)
   );

   // result packing, highest field first, header_valid in bit 0
   always_comb begin
      out_in = {dec4_ff.edit_ok, dec4_ff.new_hdr, dec4_ff.stereo, dec4_ff.flags,
                dec4_ff.crc, frame_len, dec4_ff.fs_hz, dec4_ff.rate_status,
                dec4_ff.kbit, dec4_ff.layer, dec4_ff.version, dec4_ff.hdr_ok};
   end

   // control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_tvalid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   // payload: decoded fields travel alongside the length arithmetic
   always_ff @(posedge clock) begin
      if (rdy1) begin
         dec1_ff <= dec0;
      end
      if (rdy2) begin
         dec2_ff <= dec1_ff;
      end
      if (rdy3) begin
         dec3_ff <= dec2_ff;
      end
      if (rdy4) begin
         dec4_ff <= dec3_ff;
      end
      if (rdy5) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/mahd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mahd_decode
// field split, validity checks, table lookups and header edit
// ----------------------------------------------------------------------------
module mahd_decode import mahd_pkg::*; (
   input  wire logic [HDR_W-1:0] header_word,
   input  wire logic [1:0]       req_type,
   output mahd_dec_type          dec
);

   logic [1:0]        ver;
   logic [1:0]        lay;
   logic [3:0]        bidx;
   logic [1:0]        sidx;
   logic [2:0]        tab_sel;
   logic [1:0]        status;
   logic [KBIT_W-1:0] kbit;
   logic [FS_W-1:0]   fs;
   logic              step_ok;

   always_comb begin
      case (header_word[20:19])
         2'b00:   ver = VER_MPEG25;
         2'b01:   ver = VER_RESERVED;
         2'b10:   ver = VER_MPEG2;
         default: ver = VER_MPEG1;
      endcase
      lay  = ~header_word[18:17];
      bidx = header_word[15:12];
      sidx = header_word[11:10];

      if (ver == VER_MPEG1) begin
         tab_sel = {1'b0, lay};
      end else begin
         tab_sel = (lay == LAY_I) ? 3'd3 : 3'd4;
      end

      kbit = '0;
      if (ver == VER_RESERVED || lay == LAY_RESERVED || bidx == BIDX_BAD) begin
         status = RATE_BAD;
      end else if (bidx == BIDX_FREE) begin
         status = RATE_FREE;
      end else begin
         status = RATE_NORMAL;
         kbit   = KBPS_TAB[tab_sel][bidx];
      end

      fs = (ver == VER_RESERVED) ? '0 : (FS_BASE[sidx] >> ver);

      dec.hdr_ok = (header_word[31:21] == SYNC_WORD) && (ver != VER_RESERVED)
                   && (lay != LAY_RESERVED) && (status != RATE_BAD)
                   && (fs != '0) && (header_word[1:0] != EMPH_RESERVED);
      dec.version     = ver;
      dec.layer       = lay;
      dec.kbit        = kbit;
      dec.rate_status = status;
      dec.fs_hz       = fs;
      dec.crc         = ~header_word[16];
      dec.flags       = {header_word[9], header_word[8], header_word[3], header_word[2]};
      dec.stereo      = {header_word[7:4], header_word[1:0]};

      // a step is refused at free, bad or top index
      step_ok     = (status == RATE_NORMAL) && (bidx != BIDX_LAST);
      dec.new_hdr = header_word;
      dec.edit_ok = 1'b1;
      case (req_type)
         REQ_STEP_RATE: begin
            if (step_ok) begin
               dec.new_hdr[15:12] = bidx + 4'd1;
            end else begin
               dec.edit_ok = 1'b0;
            end
         end
         REQ_CLEAR_CRC: dec.new_hdr[16] = 1'b1;
         default:       dec.new_hdr = header_word;
      endcase

      case (lay)
         LAY_I:   dec.coef1 = COEF_L1;
         LAY_II:  dec.coef1 = COEF_L23;
         default: dec.coef1 = (ver == VER_MPEG1) ? COEF_L23 : COEF_L3LS;
      endcase
      dec.fs_shift = ver;
      dec.fs_sel   = sidx;
      dec.len_ok   = (status == RATE_NORMAL) && (fs != '0);
      dec.quad     = (lay == LAY_I);
      dec.pad      = header_word[9];
   end

endmodule
`default_nettype wire

FILE: sv/mahd_frame_len.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mahd_frame_len
// pipelined frame length: product, scale, reciprocal divide, correction
// ----------------------------------------------------------------------------
module mahd_frame_len import mahd_pkg::*; (
   input  wire logic             clock,
   input  wire mahd_len_ctl_type ctl,
   input  wire mahd_dec_type     dec1,
   input  wire mahd_dec_type     dec2,
   input  wire mahd_dec_type     dec3,
   input  wire mahd_dec_type     dec4,
   output logic [FRAME_W-1:0]    frame_bytes
);

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [NUM_W-1:0]   num3_ff, num3_in;
   logic [NUM_W-1:0]   num4_ff;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [PROD_W+2:0]  scaled;
   logic [PROD_W+12:0] num_full;
   logic [MUL_W-1:0]   recip_prod;
   logic [QUO_W+FS_W-1:0] back_prod;
   logic [NUM_W-1:0]   remain;
   logic [QUO_W-1:0]   quo_fix;
   logic [QUO_W+2:0]   slots;

   always_comb begin
      prod_in    = PROD_W'(dec1.coef1 * dec1.kbit);
      scaled     = {2'b00, prod_ff} << dec2.fs_shift;
      num_full   = scaled * KBIT_SCALE;
      num3_in    = num_full[NUM_W-1:0];
      recip_prod = num3_ff * FS_RECIP[dec3.fs_sel];
      quo_in     = recip_prod[RECIP_SH+QUO_W-1:RECIP_SH];
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         prod_ff <= prod_in;
      end
      if (ctl.ld3) begin
         num3_ff <= num3_in;
      end
      if (ctl.ld4) begin
         quo_ff  <= quo_in;
         num4_ff <= num3_ff;
      end
   end

   // estimate is exact or one low
   always_comb begin
      back_prod = quo_ff * FS_BASE[dec4.fs_sel];
      remain    = num4_ff - back_prod[NUM_W-1:0];
      quo_fix   = quo_ff + QUO_W'(remain >= NUM_W'(FS_BASE[dec4.fs_sel]));
      slots     = ({3'b000, quo_fix} + (QUO_W+3)'(dec4.pad)) << (dec4.quad ? 2 : 0);
      frame_bytes = dec4.len_ok ? slots[FRAME_W-1:0] : '0;
   end

endmodule
`default_nettype wire
